// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mcfir_pkg.sv =====
`timescale 1ns / 1ps

package mcfir_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int CHAN_W     = 2;
	localparam int NCOEF      = 8;
	localparam int COEF_IDX_W = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int FRAC_W     = 14;
	localparam int PROD_W     = SAMPLE_W + COEF_W;

	localparam logic signed [COEF_W-1:0] COEF0_RESET = 16'sd16384;
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	// Controller to datapath
	typedef struct packed {
		logic load;    // latch the accepted beat
		logic issue;   // start one tap through the MAC pipe
		logic finish;  // round, saturate and load the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic tap_last;  // tap counter at the oldest-to-newest end
		logic acc_done;  // last product lands in the accumulator this cycle
		logic bypass;    // restart or channel out of range: no MAC work
	} dp_status_t;

endpackage

// ===== rtl/core/mcfir_dp.sv =====
`timescale 1ns / 1ps

module mcfir_dp #(
	parameter int TAPS     = 8,
	parameter int CHANNELS = 4
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  mcfir_pkg::dp_cmd_t                        cmd,
	output mcfir_pkg::dp_status_t                     status,
	input  logic                                      cfg_we,
	input  logic [mcfir_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [mcfir_pkg::COEF_W-1:0]              cfg_data,
	input  logic                                      command,
	input  logic [mcfir_pkg::CHAN_W-1:0]              channel,
	input  logic signed [mcfir_pkg::SAMPLE_W-1:0]     sample,
	output logic signed [mcfir_pkg::SAMPLE_W-1:0]     filtered,
	output logic [mcfir_pkg::CHAN_W-1:0]              out_channel,
	output logic                                      clipped
);

	localparam int TAP_W  = $clog2(TAPS);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W = CH_W + TAP_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int ACC_W  = mcfir_pkg::PROD_W + TAP_W;
	localparam int Y_W    = ACC_W - mcfir_pkg::FRAC_W;
	localparam int CI_W   = mcfir_pkg::COEF_IDX_W;
	localparam int SW     = mcfir_pkg::SAMPLE_W;

	logic signed [mcfir_pkg::COEF_W-1:0] coef_q [mcfir_pkg::NCOEF];
	logic signed [SW-1:0]                hist_mem [DEPTH];

	logic [CHANNELS-1:0]       primed_q;
	logic                      cmd_q;
	logic                      range_q;
	logic                      prime_q;
	logic [CH_W-1:0]           ch_idx_q;
	logic [mcfir_pkg::CHAN_W-1:0] chan_q;
	logic signed [SW-1:0]      smp_q;
	logic [TAP_W-1:0]          tap_q;

	logic                      v_s1, last_s1;
	logic [TAP_W-1:0]          tap_s1;
	logic signed [SW-1:0]      rd_s1;
	logic                      v_s2, last_s2;
	logic signed [mcfir_pkg::PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [SW-1:0]      filtered_q;
	logic [mcfir_pkg::CHAN_W-1:0] out_channel_q;
	logic                      clipped_q;

	logic [CH_W-1:0]           ch_idx;
	logic                      in_range;
	logic [TAP_W-1:0]          tap_prev;
	logic signed [SW-1:0]      tap_data;
	logic signed [mcfir_pkg::COEF_W-1:0] coef_sel;
	logic signed [ACC_W-1:0]   sum_rnd;
	logic signed [Y_W-1:0]     y;
	logic                      sat_hi, sat_lo;
	logic signed [SW-1:0]      y_sat;

	assign ch_idx   = CH_W'(channel);
	assign in_range = int'(channel) < CHANNELS;
	assign tap_prev = tap_q - TAP_W'(1);

	// Newest tap and unprimed channels take the incoming sample.
	assign tap_data = (tap_s1 == '0 || !prime_q) ? smp_q : rd_s1;
	assign coef_sel = coef_q[CI_W'(tap_s1)];

	assign sum_rnd = acc_q + ACC_W'(1 << (mcfir_pkg::FRAC_W - 1));
	assign y       = sum_rnd[ACC_W-1:mcfir_pkg::FRAC_W];
	assign sat_hi  = !y[Y_W-1] && (|y[Y_W-2:SW-1]);
	assign sat_lo  = y[Y_W-1] && !(&y[Y_W-2:SW-1]);

	always_comb begin
		if (sat_hi) begin
			y_sat = mcfir_pkg::SAT_MAX;
		end else if (sat_lo) begin
			y_sat = mcfir_pkg::SAT_MIN;
		end else begin
			y_sat = y[SW-1:0];
		end
	end

	assign status.tap_last = (tap_q == '0);
	assign status.acc_done = v_s2 && last_s2;
	assign status.bypass   = cmd_q || !range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcfir_pkg::NCOEF; i++) begin
				coef_q[i] <= (i == 0) ? mcfir_pkg::COEF0_RESET : '0;
			end
		end else if (cfg_we && int'(cfg_index) < mcfir_pkg::NCOEF) begin
			coef_q[cfg_index[CI_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= '0;
			cmd_q    <= 1'b0;
			range_q  <= 1'b0;
			prime_q  <= 1'b0;
			tap_q    <= '0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			if (cmd.load) begin
				cmd_q   <= command;
				range_q <= in_range;
				prime_q <= in_range && primed_q[ch_idx];
				tap_q   <= TAP_W'(TAPS - 1);
				if (command) begin
					primed_q <= '0;
				end else if (in_range) begin
					primed_q[ch_idx] <= 1'b1;
				end
			end else if (cmd.issue) begin
				tap_q <= tap_prev;
			end
			v_s1    <= cmd.issue;
			last_s1 <= cmd.issue && (tap_q == '0);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_idx_q <= ch_idx;
			chan_q   <= channel;
			smp_q    <= sample;
			acc_q    <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.issue) begin
			tap_s1 <= tap_q;
			rd_s1  <= hist_mem[{ch_idx_q, tap_prev}];
		end
		// Shift the delay line one slot older as each tap passes.
		if (v_s1) begin
			hist_mem[{ch_idx_q, tap_s1}] <= tap_data;
			prod_s2 <= coef_sel * tap_data;
		end
		if (cmd.finish) begin
			out_channel_q <= chan_q;
			filtered_q    <= status.bypass ? '0 : y_sat;
			clipped_q     <= !status.bypass && (sat_hi || sat_lo);
		end
	end

	assign filtered    = filtered_q;
	assign out_channel = out_channel_q;
	assign clipped     = clipped_q;

endmodule

// ===== rtl/core/mcfir_ctrl.sv =====
`timescale 1ns / 1ps

module mcfir_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mcfir_pkg::dp_cmd_t    cmd,
	input  mcfir_pkg::dp_status_t status
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (status.bypass) begin
					state_d = S_FIN;
				end else begin
					cmd.issue = 1'b1;
					if (status.tap_last) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				if (status.acc_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// hold until the output register can take the beat
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/multichannel_fir_filter.sv =====
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    command, channel, sample
// out      out_valid / out_ready  filtered, out_channel, clipped
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A filter beat does one multiply-accumulate per tap through the single MAC
// and the history memory; no new beat is accepted until it is done.
// A restart or out-of-range channel beat skips the MAC work.
// Reset clears the primed flags and restores the coefficients; no memory sweep.
// A result waiting on out_ready holds the output register; the next beat is
// still accepted and its result waits until the register frees.

module multichannel_fir_filter #(
	parameter int TAPS     = 8,
	parameter int CHANNELS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [mcfir_pkg::CHAN_W-1:0]          channel,
	input  logic signed [mcfir_pkg::SAMPLE_W-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mcfir_pkg::SAMPLE_W-1:0] filtered,
	output logic [mcfir_pkg::CHAN_W-1:0]          out_channel,
	output logic                                  clipped,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mcfir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcfir_pkg::COEF_W-1:0]          cfg_data
);

	mcfir_pkg::dp_cmd_t    dp_cmd;
	mcfir_pkg::dp_status_t dp_status;

	assign cfg_ready = 1'b1;

	mcfir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	mcfir_dp #(
		.TAPS     (TAPS),
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.status      (dp_status),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (command),
		.channel     (channel),
		.sample      (sample),
		.filtered    (filtered),
		.out_channel (out_channel),
		.clipped     (clipped)
	);

endmodule

// ===== rtl/core/mcfir_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcfir_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [mcfir_pkg::SAMPLE_W-1:0] filtered,
	input logic                                  clipped
);

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(filtered), "output beat dropped or changed while stalled")
	`CHK_SAME(a_clip_rail, clk, arst_n, out_valid && clipped, filtered == mcfir_pkg::SAT_MAX || filtered == mcfir_pkg::SAT_MIN, "clipped result not on a rail")
	`CHK_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready, "second beat taken while one is in work")

endmodule

bind multichannel_fir_filter mcfir_chk u_mcfir_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.filtered  (filtered),
	.clipped   (clipped)
);
